FILE: hdl/f4avt_pkg.sv
package f4avt_pkg;

   // Number of scanner table slots, one chain cell per slot.
   localparam int SCANNER_SLOTS = 16;
   localparam int SLOT_W        = (SCANNER_SLOTS > 1) ? $clog2(SCANNER_SLOTS) : 1;
   localparam int SCAN_POP_W    = $clog2(SCANNER_SLOTS + 1);

   localparam int ADV_HANDLES   = 256;
   localparam int ADV_POP_W     = 9;

   localparam int COMMAND_W     = 3;
   localparam int HANDLE_W      = 8;
   localparam int SCANNER_ID_W  = 32;
   localparam int CODE_W        = 8;

   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 8;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_ADV_START  = 3'd0,
      CMD_ADV_REMOVE = 3'd1,
      CMD_SCAN_START = 3'd2,
      CMD_SCAN_STOP  = 3'd3,
      CMD_ALL_STOP   = 3'd4
   } command_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_ADV_FRAME4  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCAN_FRAME4 = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MONITOR     = 2'd2;

   localparam logic [CODE_W-1:0] ADV_FRAME4_RESET  = 8'd4;
   localparam logic [CODE_W-1:0] SCAN_FRAME4_RESET = 8'd4;
   localparam logic [CODE_W-1:0] MONITOR_RESET     = 8'd3;

   localparam logic KIND_ANTENNA    = 1'b0;
   localparam logic KIND_TABLE_FULL = 1'b1;
   localparam logic SCENE_ADV       = 1'b0;
   localparam logic SCENE_SCAN      = 1'b1;

   // Search token that walks down the scanner cell chain.
   typedef struct packed {
      logic                    active;
      logic                    stop;
      logic [SCANNER_ID_W-1:0] scanner_id;
      logic                    found;
      logic                    free_found;
      logic [SLOT_W-1:0]       free_idx;
   } token_type;

   // Broadcast update from the controller to every cell.
   typedef struct packed {
      logic                    en;
      logic                    clear_all;
      logic [SLOT_W-1:0]       idx;
      logic [SCANNER_ID_W-1:0] scanner_id;
   } slot_write_type;

endpackage

FILE: hdl/f4avt_ifs.sv
interface f4avt_req_if;
   logic                                valid;
   logic                                ready;
   logic [f4avt_pkg::COMMAND_W-1:0]     command;
   logic [f4avt_pkg::HANDLE_W-1:0]      adv_handle;
   logic [f4avt_pkg::SCANNER_ID_W-1:0]  scanner_id;
   logic [f4avt_pkg::CODE_W-1:0]        scan_mode;
   logic [f4avt_pkg::CODE_W-1:0]        frame_type;

   modport source (output valid, command, adv_handle, scanner_id, scan_mode, frame_type,
                   input ready);
   modport sink   (input valid, command, adv_handle, scanner_id, scan_mode, frame_type,
                   output ready);
endinterface

interface f4avt_rsp_if;
   logic valid;
   logic ready;
   logic kind;
   logic scene;
   logic fix_on;

   modport source (output valid, kind, scene, fix_on, input ready);
   modport sink   (input valid, kind, scene, fix_on, output ready);
endinterface

FILE: hdl/frame4_antenna_vote_tracker.sv
// Frame-4 antenna vote tracker. The block counts two groups of users that
// need the antenna held fixed: frame-4 advertisers, kept by 8-bit handle in
// a 256-bit membership map, and frame-4 scanners, kept by 32-bit id in a
// table of SCANNER_SLOTS slots built as a chain of cells. When either count
// rises from zero a fix-on item is sent for that scene, and when it falls
// back to zero a fix-off item follows; a scan start that finds the table
// full is dropped and reported with a table-full item. Each accepted
// command gives zero or one result item. Commands are taken one at a time.
// Advertiser commands and the all-scans-stopped command are settled in the
// decide state; scan start and scan stop send a search token down the cell
// chain, one cell per cycle, and are settled in the walk state when it leaves
// the last cell. A result item then passes through the emit state into an
// output register, so the next command is accepted while an earlier result
// still waits to be taken; the block only stalls when a second result is
// ready before the first has left. Configuration registers are written through
// the csr port only while the block is idle; the user must keep to this, as
// the block itself does not enforce it. Reset restores their defaults.
module frame4_antenna_vote_tracker (
   input  logic                                  clock,
   input  logic                                  reset,
   f4avt_req_if.sink                             req_chan,
   f4avt_rsp_if.source                           rsp_chan,
   input  logic                                  csr_we,
   input  logic [f4avt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [f4avt_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_WALK,
      ST_EMIT
   } state_type;

   state_type                               state_ff, state_in;

   // Latched command fields.
   f4avt_pkg::command_type                  cmd_ff, cmd_in;
   logic [f4avt_pkg::HANDLE_W-1:0]          handle_ff, handle_in;
   logic [f4avt_pkg::SCANNER_ID_W-1:0]      id_ff, id_in;
   logic [f4avt_pkg::CODE_W-1:0]            mode_ff, mode_in;
   logic [f4avt_pkg::CODE_W-1:0]            ftype_ff, ftype_in;

   // Configuration registers.
   logic [f4avt_pkg::CODE_W-1:0]            adv_code_ff, adv_code_in;
   logic [f4avt_pkg::CODE_W-1:0]            scan_code_ff, scan_code_in;
   logic [f4avt_pkg::CODE_W-1:0]            monitor_code_ff, monitor_code_in;

   // Advertiser membership map and both population counts.
   logic [f4avt_pkg::ADV_HANDLES-1:0]       adv_map_ff, adv_map_in;
   logic [f4avt_pkg::ADV_POP_W-1:0]         adv_pop_ff, adv_pop_in;
   logic [f4avt_pkg::SCAN_POP_W-1:0]        scan_pop_ff, scan_pop_in;

   // Pending result, then the output register.
   logic                                    pend_kind_ff, pend_kind_in;
   logic                                    pend_scene_ff, pend_scene_in;
   logic                                    pend_fix_ff, pend_fix_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic                                    rsp_kind_ff, rsp_kind_in;
   logic                                    rsp_scene_ff, rsp_scene_in;
   logic                                    rsp_fix_ff, rsp_fix_in;

   logic                                    out_free;
   f4avt_pkg::token_type                    chain [f4avt_pkg::SCANNER_SLOTS+1];
   f4avt_pkg::token_type                    launch;
   f4avt_pkg::token_type                    tail;
   f4avt_pkg::slot_write_type               slot_wr;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign chain[0]       = launch;
   assign tail           = chain[f4avt_pkg::SCANNER_SLOTS];

   // The scanner table: one cell per slot, the token moving one cell a cycle.
   for (genvar i = 0; i < f4avt_pkg::SCANNER_SLOTS; i++) begin : g_cell
      f4avt_scan_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (f4avt_pkg::SLOT_W'(i)),
         .tok_in     (chain[i]),
         .slot_wr    (slot_wr),
         .tok_out    (chain[i+1])
      );
   end

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      handle_in       = handle_ff;
      id_in           = id_ff;
      mode_in         = mode_ff;
      ftype_in        = ftype_ff;
      adv_code_in     = adv_code_ff;
      scan_code_in    = scan_code_ff;
      monitor_code_in = monitor_code_ff;
      adv_map_in      = adv_map_ff;
      adv_pop_in      = adv_pop_ff;
      scan_pop_in     = scan_pop_ff;
      pend_kind_in    = pend_kind_ff;
      pend_scene_in   = pend_scene_ff;
      pend_fix_in     = pend_fix_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_scene_in    = rsp_scene_ff;
      rsp_fix_in      = rsp_fix_ff;
      launch          = '0;
      slot_wr         = '0;

      // Writes to an index with no register behind it are dropped.
      if (csr_we) begin
         unique case (csr_index)
            f4avt_pkg::CSR_ADV_FRAME4:  adv_code_in     = csr_wdata;
            f4avt_pkg::CSR_SCAN_FRAME4: scan_code_in    = csr_wdata;
            f4avt_pkg::CSR_MONITOR:     monitor_code_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in    = f4avt_pkg::command_type'(req_chan.command);
               handle_in = req_chan.adv_handle;
               id_in     = req_chan.scanner_id;
               mode_in   = req_chan.scan_mode;
               ftype_in  = req_chan.frame_type;
               state_in  = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            state_in = ST_IDLE;
            unique case (cmd_ff)
               f4avt_pkg::CMD_ADV_START: begin
                  // Only a new frame-4 handle counts.
                  if (ftype_ff == adv_code_ff && !adv_map_ff[handle_ff]) begin
                     adv_map_in[handle_ff] = 1'b1;
                     adv_pop_in            = adv_pop_ff + 1'b1;
                     if (adv_pop_ff == '0) begin
                        pend_kind_in  = f4avt_pkg::KIND_ANTENNA;
                        pend_scene_in = f4avt_pkg::SCENE_ADV;
                        pend_fix_in   = 1'b1;
                        state_in      = ST_EMIT;
                     end
                  end
               end
               f4avt_pkg::CMD_ADV_REMOVE: begin
                  if (adv_map_ff[handle_ff]) begin
                     adv_map_in[handle_ff] = 1'b0;
                     adv_pop_in            = adv_pop_ff - 1'b1;
                     if (adv_pop_ff == f4avt_pkg::ADV_POP_W'(1)) begin
                        pend_kind_in  = f4avt_pkg::KIND_ANTENNA;
                        pend_scene_in = f4avt_pkg::SCENE_ADV;
                        pend_fix_in   = 1'b0;
                        state_in      = ST_EMIT;
                     end
                  end
               end
               f4avt_pkg::CMD_SCAN_START, f4avt_pkg::CMD_SCAN_STOP: begin
                  // A start in monitor mode or of another frame type is a stop.
                  launch.active     = 1'b1;
                  launch.stop       = (cmd_ff == f4avt_pkg::CMD_SCAN_STOP) ||
                                      (mode_ff == monitor_code_ff) ||
                                      (ftype_ff != scan_code_ff);
                  launch.scanner_id = id_ff;
                  state_in          = ST_WALK;
               end
               f4avt_pkg::CMD_ALL_STOP: begin
                  if (scan_pop_ff != '0) begin
                     slot_wr.clear_all = 1'b1;
                     scan_pop_in       = '0;
                     pend_kind_in      = f4avt_pkg::KIND_ANTENNA;
                     pend_scene_in     = f4avt_pkg::SCENE_SCAN;
                     pend_fix_in       = 1'b0;
                     state_in          = ST_EMIT;
                  end
               end
               default: ;
            endcase
         end

         ST_WALK: begin
            // The token leaves the last cell carrying the search outcome.
            if (tail.active) begin
               state_in      = ST_IDLE;
               pend_kind_in  = f4avt_pkg::KIND_ANTENNA;
               pend_scene_in = f4avt_pkg::SCENE_SCAN;
               pend_fix_in   = 1'b0;
               priority if (tail.stop) begin
                  if (tail.found) begin
                     scan_pop_in = scan_pop_ff - 1'b1;
                     if (scan_pop_ff == f4avt_pkg::SCAN_POP_W'(1)) begin
                        state_in = ST_EMIT;
                     end
                  end
               end else if (tail.found) begin
                  state_in = ST_IDLE;
               end else if (!tail.free_found) begin
                  pend_kind_in = f4avt_pkg::KIND_TABLE_FULL;
                  state_in     = ST_EMIT;
               end else begin
                  slot_wr.en         = 1'b1;
                  slot_wr.idx        = tail.free_idx;
                  slot_wr.scanner_id = id_ff;
                  scan_pop_in        = scan_pop_ff + 1'b1;
                  if (scan_pop_ff == '0) begin
                     pend_fix_in = 1'b1;
                     state_in    = ST_EMIT;
                  end
               end
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_scene_in = pend_scene_ff;
               rsp_fix_in   = pend_fix_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      handle_ff     <= handle_in;
      id_ff         <= id_in;
      mode_ff       <= mode_in;
      ftype_ff      <= ftype_in;
      pend_kind_ff  <= pend_kind_in;
      pend_scene_ff <= pend_scene_in;
      pend_fix_ff   <= pend_fix_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_scene_ff  <= rsp_scene_in;
      rsp_fix_ff    <= rsp_fix_in;
      if (reset) begin
         state_ff        <= ST_IDLE;
         adv_code_ff     <= f4avt_pkg::ADV_FRAME4_RESET;
         scan_code_ff    <= f4avt_pkg::SCAN_FRAME4_RESET;
         monitor_code_ff <= f4avt_pkg::MONITOR_RESET;
         adv_map_ff      <= '0;
         adv_pop_ff      <= '0;
         scan_pop_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         adv_code_ff     <= adv_code_in;
         scan_code_ff    <= scan_code_in;
         monitor_code_ff <= monitor_code_in;
         adv_map_ff      <= adv_map_in;
         adv_pop_ff      <= adv_pop_in;
         scan_pop_ff     <= scan_pop_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.kind   = rsp_kind_ff;
   assign rsp_chan.scene  = rsp_scene_ff;
   assign rsp_chan.fix_on = rsp_fix_ff;

   a_token_in_walk: assert property (@(posedge clock) disable iff (reset)
      tail.active |-> (state_ff == ST_WALK))
      else $error("search token left the chain outside the walk");

   a_scan_pop_bound: assert property (@(posedge clock) disable iff (reset)
      scan_pop_ff <= f4avt_pkg::SCAN_POP_W'(f4avt_pkg::SCANNER_SLOTS))
      else $error("scanner count exceeds the table size");

   a_insert_clean: assert property (@(posedge clock) disable iff (reset)
      slot_wr.en |-> (tail.active && !tail.stop && !tail.found && tail.free_found))
      else $error("slot written without a free slot and a missed search");

   a_emit_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("pending result was not moved to the output register");

endmodule

FILE: hdl/f4avt_scan_cell.sv
// One scanner table slot. It compares the passing token with its own id,
// frees itself on a matching stop; the first empty slot marks itself free.
module f4avt_scan_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [f4avt_pkg::SLOT_W-1:0]  cell_index,
   input  f4avt_pkg::token_type          tok_in,
   input  f4avt_pkg::slot_write_type     slot_wr,
   output f4avt_pkg::token_type          tok_out
);

   logic                                 valid_ff, valid_in;
   logic [f4avt_pkg::SCANNER_ID_W-1:0]   id_ff, id_in;
   f4avt_pkg::token_type                 tok_ff, tok_in_next;
   logic                                 hit;
   logic                                 wr_here;

   assign hit     = tok_in.active && valid_ff && (id_ff == tok_in.scanner_id);
   assign wr_here = slot_wr.en && (slot_wr.idx == cell_index);

   always_comb begin
      valid_in = valid_ff;
      id_in    = id_ff;
      priority if (slot_wr.clear_all) begin
         valid_in = 1'b0;
      end else if (wr_here) begin
         valid_in = 1'b1;
         id_in    = slot_wr.scanner_id;
      end else if (hit && tok_in.stop) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end

      tok_in_next       = tok_in;
      tok_in_next.found = tok_in.found || hit;
      if (tok_in.active && !valid_ff && !tok_in.free_found) begin
         tok_in_next.free_found = 1'b1;
         tok_in_next.free_idx   = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

   a_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (wr_here && !slot_wr.clear_all) |=> valid_ff)
      else $error("written slot did not become valid");

   a_clear_all: assert property (@(posedge clock) disable iff (reset)
      slot_wr.clear_all |=> !valid_ff)
      else $error("slot survived a clear of the whole table");

   a_stop_frees: assert property (@(posedge clock) disable iff (reset)
      (hit && tok_in.stop && !slot_wr.en) |=> !valid_ff)
      else $error("matching stop did not free the slot");

endmodule

FILE: test/tb_frame4_antenna_vote_tracker.sv
`timescale 1ns / 1ps

// Self-checking bench for the frame-4 antenna vote tracker.
//
// An initial block fills a queue of pending command items. A driver clocked
// on the falling edge feeds them through the request channel with random
// gaps. A monitor clocked on the rising edge samples both handshakes. Every
// accepted command is run through a local vote model, which keeps its own
// advertiser roster, scanner slot table and register copies, and which queues
// the antenna note it expects. Every accepted result is checked field by field
// against the oldest waiting note. Register writes only happen while the block
// is idle, between phases, and each phase runs under a different set of codes.
module tb_frame4_antenna_vote_tracker;
   import f4avt_pkg::*;

   localparam int PHASE_ITEMS   = 210;
   localparam int ID_POOL_SIZE  = 20;
   localparam int MAX_GAP       = 6;
   localparam int MAX_REPORTS   = 10;
   // A scan command walks the whole slot chain, so the quiet time after the
   // last result leaves room for more than one full search.
   localparam int SETTLE_CYCLES = 2 * SCANNER_SLOTS + 8;
   localparam int DRAIN_LIMIT   = 20000;

   // Command values past the defined set; the block must ignore them.
   localparam logic [COMMAND_W-1:0]   CMD_SPARE_FIRST = 3'd5;
   localparam logic [COMMAND_W-1:0]   CMD_SPARE_LAST  = 3'd7;
   // Register index with no register behind it; writes there are dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE       = 2'd3;

   typedef struct packed {
      logic [COMMAND_W-1:0]    command;
      logic [HANDLE_W-1:0]     handle;
      logic [SCANNER_ID_W-1:0] scanner_id;
      logic [CODE_W-1:0]       scan_mode;
      logic [CODE_W-1:0]       frame_type;
   } vote_cmd_type;

   typedef struct packed {
      logic kind;
      logic scene;
      logic fix_on;
   } antenna_note_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   f4avt_req_if req_bus ();
   f4avt_rsp_if rsp_bus ();

   frame4_antenna_vote_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Vote model state, updated at the rising edge that accepts a command.
   logic [CODE_W-1:0]       adv_code_seen;
   logic [CODE_W-1:0]       scan_code_seen;
   logic [CODE_W-1:0]       monitor_code_seen;
   bit                      adv_roster [ADV_HANDLES];
   int                      adv_headcount;
   logic [SCANNER_ID_W-1:0] scan_ids [SCANNER_SLOTS];
   bit                      scan_live [SCANNER_SLOTS];
   int                      scan_headcount;
   antenna_note_type        awaited_notes [$];

   // Command traffic and handshake pacing.
   vote_cmd_type            pending_cmds [$];
   vote_cmd_type            in_flight;
   bit                      req_taken;
   int                      req_gap;
   bit                      req_burst;
   int                      rsp_stall;
   bit                      rsp_burst;
   int                      failures;

   // The stimulus side keeps its own view of the codes so that it can aim
   // most commands at the frame-4 path, plus a superset of the handles that
   // may be counted so that advertiser teardowns really reach zero.
   logic [CODE_W-1:0]       gen_adv_code;
   logic [CODE_W-1:0]       gen_scan_code;
   logic [CODE_W-1:0]       gen_mon_code;
   bit                      adv_maybe [ADV_HANDLES];
   logic [SCANNER_ID_W-1:0] scan_id_pool [ID_POOL_SIZE];
   int                      queued_count;

   task automatic count_failure(input string what);
      failures++;
      if (failures <= MAX_REPORTS) $display("%0t: %s", $time, what);
   endtask

   function automatic logic [CODE_W-1:0] rand_code();
      return CODE_W'($urandom);
   endfunction

   function automatic logic [HANDLE_W-1:0] rand_handle();
      return HANDLE_W'($urandom);
   endfunction

   task automatic expect_note(input logic kind, input logic scene, input logic fix_on);
      antenna_note_type n;
      n.kind   = kind;
      n.scene  = scene;
      n.fix_on = fix_on;
      awaited_notes.push_back(n);
   endtask

   task automatic reset_vote_model();
      adv_code_seen     = ADV_FRAME4_RESET;
      scan_code_seen    = SCAN_FRAME4_RESET;
      monitor_code_seen = MONITOR_RESET;
      foreach (adv_roster[h]) adv_roster[h] = 1'b0;
      foreach (scan_live[s]) scan_live[s] = 1'b0;
      adv_headcount  = 0;
      scan_headcount = 0;
      awaited_notes.delete();
   endtask

   // Frees the slot holding this scanner, if any. Losing the last scanner
   // releases the antenna for the scanning scene.
   task automatic release_scanner(input logic [SCANNER_ID_W-1:0] id);
      bit hit;
      hit = 1'b0;
      for (int s = 0; s < SCANNER_SLOTS; s++) begin
         if (!hit && scan_live[s] && scan_ids[s] == id) begin
            hit          = 1'b1;
            scan_live[s] = 1'b0;
            if (scan_headcount > 0) scan_headcount--;
            if (scan_headcount == 0) expect_note(KIND_ANTENNA, SCENE_SCAN, 1'b0);
         end
      end
   endtask

   task automatic tally_vote(input vote_cmd_type c);
      bit known;
      int open_slot;
      known     = 1'b0;
      open_slot = -1;
      case (c.command)
         CMD_ADV_START: begin
            // Only frame-4 advertisers count, and each handle counts once.
            if (c.frame_type == adv_code_seen && !adv_roster[c.handle]) begin
               adv_roster[c.handle] = 1'b1;
               adv_headcount++;
               if (adv_headcount == 1) expect_note(KIND_ANTENNA, SCENE_ADV, 1'b1);
            end
         end
         CMD_ADV_REMOVE: begin
            if (adv_roster[c.handle]) begin
               adv_roster[c.handle] = 1'b0;
               if (adv_headcount > 0) adv_headcount--;
               if (adv_headcount == 0) expect_note(KIND_ANTENNA, SCENE_ADV, 1'b0);
            end
         end
         CMD_SCAN_START: begin
            // A monitor-mode start or a start of another frame type stops
            // that scanner instead.
            if (c.scan_mode == monitor_code_seen || c.frame_type != scan_code_seen) begin
               release_scanner(c.scanner_id);
            end else begin
               for (int s = 0; s < SCANNER_SLOTS; s++) begin
                  if (scan_live[s]) begin
                     if (scan_ids[s] == c.scanner_id) known = 1'b1;
                  end else if (open_slot < 0) begin
                     open_slot = s;
                  end
               end
               if (!known) begin
                  if (open_slot < 0) begin
                     expect_note(KIND_TABLE_FULL, SCENE_SCAN, 1'b0);
                  end else begin
                     scan_ids[open_slot]  = c.scanner_id;
                     scan_live[open_slot] = 1'b1;
                     scan_headcount++;
                     if (scan_headcount == 1) expect_note(KIND_ANTENNA, SCENE_SCAN, 1'b1);
                  end
               end
            end
         end
         CMD_SCAN_STOP: begin
            release_scanner(c.scanner_id);
         end
         CMD_ALL_STOP: begin
            if (scan_headcount > 0) begin
               foreach (scan_live[s]) scan_live[s] = 1'b0;
               scan_headcount = 0;
               expect_note(KIND_ANTENNA, SCENE_SCAN, 1'b0);
            end
         end
         default: begin
         end
      endcase
   endtask

   // Each side waits a random gap after each item, except during bursts,
   // which come and go at random and have no waits at all.
   function automatic int draw_gap(inout bit burst);
      if ($urandom_range(0, 39) == 0) burst = !burst;
      return burst ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Monitor: checks results, runs the vote model on accepted commands and
   // mirrors register writes, all on values sampled at the rising edge.
   always @(posedge clock) begin
      antenna_note_type got;
      antenna_note_type want;
      if (reset) begin
         reset_vote_model();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.kind   = rsp_bus.kind;
            got.scene  = rsp_bus.scene;
            got.fix_on = rsp_bus.fix_on;
            rsp_stall  = draw_gap(rsp_burst);
            if (awaited_notes.size() == 0) begin
               count_failure($sformatf(
                  "result with none awaited: kind=%0d scene=%0d fix_on=%0d",
                  got.kind, got.scene, got.fix_on));
            end else begin
               want = awaited_notes.pop_front();
               if (got.kind !== want.kind || got.scene !== want.scene ||
                   got.fix_on !== want.fix_on) begin
                  count_failure($sformatf(
                     "expected kind=%0d scene=%0d fix_on=%0d, got kind=%0d scene=%0d fix_on=%0d",
                     want.kind, want.scene, want.fix_on, got.kind, got.scene, got.fix_on));
               end
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            tally_vote(in_flight);
            req_taken = 1'b1;
            req_gap   = draw_gap(req_burst);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ADV_FRAME4:  adv_code_seen     = csr_wdata;
               CSR_SCAN_FRAME4: scan_code_seen    = csr_wdata;
               CSR_MONITOR:     monitor_code_seen = csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Driver: a command item stays on the bus until it is accepted, then the
   // next one follows after its gap. Valid gets one assignment per edge.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_bus.valid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            in_flight = pending_cmds.pop_front();
            req_bus.command    <= in_flight.command;
            req_bus.adv_handle <= in_flight.handle;
            req_bus.scanner_id <= in_flight.scanner_id;
            req_bus.scan_mode  <= in_flight.scan_mode;
            req_bus.frame_type <= in_flight.frame_type;
            req_bus.valid      <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // Result side: ready drops for a random stall after each accepted result.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic queue_cmd(input logic [COMMAND_W-1:0] command,
                            input logic [HANDLE_W-1:0] handle,
                            input logic [SCANNER_ID_W-1:0] id,
                            input logic [CODE_W-1:0] mode,
                            input logic [CODE_W-1:0] ftype);
      vote_cmd_type c;
      c.command    = command;
      c.handle     = handle;
      c.scanner_id = id;
      c.scan_mode  = mode;
      c.frame_type = ftype;
      pending_cmds.push_back(c);
      queued_count++;
      if (command == CMD_ADV_START) adv_maybe[handle] = 1'b1;
      if (command == CMD_ADV_REMOVE) adv_maybe[handle] = 1'b0;
   endtask

   // Fields a command does not use are filled at random all the same.
   task automatic adv_cmd(input logic [COMMAND_W-1:0] command,
                          input logic [HANDLE_W-1:0] handle,
                          input logic [CODE_W-1:0] ftype);
      queue_cmd(command, handle, $urandom, rand_code(), ftype);
   endtask

   task automatic scan_cmd(input logic [COMMAND_W-1:0] command,
                           input logic [SCANNER_ID_W-1:0] id,
                           input logic [CODE_W-1:0] mode,
                           input logic [CODE_W-1:0] ftype);
      queue_cmd(command, rand_handle(), id, mode, ftype);
   endtask

   function automatic logic [CODE_W-1:0] other_code(input logic [CODE_W-1:0] code);
      return code ^ CODE_W'($urandom_range(1, 255));
   endfunction

   function automatic logic [CODE_W-1:0] plain_mode();
      logic [CODE_W-1:0] m;
      m = rand_code();
      if (m == gen_mon_code) m = ~m;
      return m;
   endfunction

   // Directed opening under the reset codes: field extremes, every command
   // and the ignore and stop-instead-of-start cases.
   task automatic queue_directed();
      adv_cmd(CMD_ADV_START, 8'h00, gen_adv_code);
      adv_cmd(CMD_ADV_START, 8'hFF, gen_adv_code);
      adv_cmd(CMD_ADV_START, 8'h00, gen_adv_code);
      adv_cmd(CMD_ADV_START, 8'h07, other_code(gen_adv_code));
      adv_cmd(CMD_ADV_REMOVE, 8'h09, rand_code());
      adv_cmd(CMD_ADV_REMOVE, 8'h00, rand_code());
      adv_cmd(CMD_ADV_REMOVE, 8'hFF, rand_code());
      scan_cmd(CMD_SCAN_START, 32'h0000_0000, 8'h00, gen_scan_code);
      scan_cmd(CMD_SCAN_START, 32'hFFFF_FFFF, 8'hFF, gen_scan_code);
      scan_cmd(CMD_SCAN_START, 32'h0000_0000, 8'h00, gen_scan_code);
      scan_cmd(CMD_SCAN_START, 32'hFFFF_FFFF, gen_mon_code, gen_scan_code);
      scan_cmd(CMD_SCAN_START, 32'h0000_0000, 8'h00, other_code(gen_scan_code));
      scan_cmd(CMD_SCAN_STOP, 32'h0000_0005, rand_code(), rand_code());
      scan_cmd(CMD_ALL_STOP, $urandom, rand_code(), rand_code());
      queue_cmd(CMD_SPARE_FIRST, rand_handle(), $urandom, rand_code(), rand_code());
      queue_cmd(CMD_SPARE_LAST, rand_handle(), $urandom, rand_code(), rand_code());
   endtask

   // Fills every slot, overflows the table, frees a middle slot and refills
   // it, then tears the scanners down again.
   task automatic queue_table_overflow();
      logic [SCANNER_ID_W-1:0] fresh [SCANNER_SLOTS + 2];
      logic [SCANNER_ID_W-1:0] late_id;
      scan_cmd(CMD_ALL_STOP, $urandom, rand_code(), rand_code());
      foreach (fresh[k]) begin
         fresh[k] = $urandom;
         scan_cmd(CMD_SCAN_START, fresh[k], plain_mode(), gen_scan_code);
      end
      late_id = $urandom;
      scan_cmd(CMD_SCAN_STOP, fresh[SCANNER_SLOTS / 2], rand_code(), rand_code());
      scan_cmd(CMD_SCAN_START, late_id, plain_mode(), gen_scan_code);
      scan_cmd(CMD_SCAN_START, fresh[SCANNER_SLOTS], plain_mode(), gen_scan_code);
      if ($urandom_range(0, 1) == 0) begin
         scan_cmd(CMD_ALL_STOP, $urandom, rand_code(), rand_code());
      end else begin
         foreach (fresh[k]) scan_cmd(CMD_SCAN_STOP, fresh[k], rand_code(), rand_code());
         scan_cmd(CMD_SCAN_STOP, late_id, rand_code(), rand_code());
      end
   endtask

   task automatic queue_adv_session();
      logic [HANDLE_W-1:0] base;
      logic [HANDLE_W-1:0] h;
      base = rand_handle();
      repeat ($urandom_range(3, 12)) begin
         h = base + HANDLE_W'($urandom_range(0, 7));
         if ($urandom_range(0, 9) < 6)
            adv_cmd(CMD_ADV_START, h,
                    ($urandom_range(0, 9) < 8) ? gen_adv_code : other_code(gen_adv_code));
         else
            adv_cmd(CMD_ADV_REMOVE, h, rand_code());
      end
      // Most sessions end by removing every handle that may be counted, so
      // the advertising count keeps returning to zero.
      if ($urandom_range(0, 2) != 0) begin
         for (int k = 0; k < ADV_HANDLES; k++) begin
            if (adv_maybe[k]) adv_cmd(CMD_ADV_REMOVE, HANDLE_W'(k), rand_code());
         end
      end
   endtask

   // The id pool is larger than the table, so long sessions overflow it.
   task automatic queue_scan_session();
      logic [SCANNER_ID_W-1:0] id;
      int pick;
      repeat ($urandom_range(4, 24)) begin
         id   = scan_id_pool[$urandom_range(0, ID_POOL_SIZE - 1)];
         pick = $urandom_range(0, 19);
         if (pick < 11)
            scan_cmd(CMD_SCAN_START, id, plain_mode(), gen_scan_code);
         else if (pick < 12)
            scan_cmd(CMD_SCAN_START, id, gen_mon_code, rand_code());
         else if (pick < 13)
            scan_cmd(CMD_SCAN_START, id, plain_mode(), other_code(gen_scan_code));
         else if (pick < 19)
            scan_cmd(CMD_SCAN_STOP, id, rand_code(), rand_code());
         else
            scan_cmd(CMD_SCAN_STOP, $urandom, rand_code(), rand_code());
      end
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         scan_cmd(CMD_ALL_STOP, $urandom, rand_code(), rand_code());
      end else if (pick < 8) begin
         foreach (scan_id_pool[k])
            scan_cmd(CMD_SCAN_STOP, scan_id_pool[k], rand_code(), rand_code());
      end
   endtask

   task automatic queue_random_phase(input int target);
      int stop_at;
      int pick;
      stop_at = queued_count + target;
      foreach (scan_id_pool[k]) scan_id_pool[k] = $urandom;
      scan_id_pool[0]                = '0;
      scan_id_pool[ID_POOL_SIZE - 1] = '1;
      queue_table_overflow();
      while (queued_count < stop_at) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            queue_adv_session();
         end else if (pick < 7) begin
            queue_scan_session();
         end else if (pick == 7) begin
            queue_table_overflow();
         end else begin
            // Raw noise, including the undefined command values.
            repeat ($urandom_range(2, 6))
               queue_cmd(COMMAND_W'($urandom_range(CMD_ADV_START, CMD_SPARE_LAST)),
                         rand_handle(), $urandom, rand_code(), rand_code());
         end
      end
   endtask

   // Waits until every command has gone in and every awaited result has come out
   // or the drain limit is hit, then lets the block settle and reports missing results.
   task automatic settle_block();
      int waited;
      waited = 0;
      while ((pending_cmds.size() > 0 || req_bus.valid || awaited_notes.size() > 0) &&
             waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_notes.size() > 0)
         count_failure($sformatf("%0d results never arrived", awaited_notes.size()));
   endtask

   task automatic write_code(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_ADV_FRAME4:  gen_adv_code  = val;
         CSR_SCAN_FRAME4: gen_scan_code = val;
         CSR_MONITOR:     gen_mon_code  = val;
         default: begin
         end
      endcase
   endtask

   initial begin
      csr_we             = 1'b0;
      csr_index          = CSR_ADV_FRAME4;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_ADV_START;
      req_bus.adv_handle = '0;
      req_bus.scanner_id = '0;
      req_bus.scan_mode  = '0;
      req_bus.frame_type = '0;
      rsp_bus.ready      = 1'b0;
      req_taken          = 1'b0;
      req_gap            = 0;
      req_burst          = 1'b0;
      rsp_stall          = 0;
      rsp_burst          = 1'b0;
      failures           = 0;
      queued_count       = 0;
      gen_adv_code       = ADV_FRAME4_RESET;
      gen_scan_code      = SCAN_FRAME4_RESET;
      gen_mon_code       = MONITOR_RESET;
      foreach (adv_maybe[h]) adv_maybe[h] = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase one runs on the reset codes.
      queue_directed();
      queue_random_phase(PHASE_ITEMS);
      settle_block();

      // Lowest and highest codes, in both pairings.
      write_code(CSR_ADV_FRAME4, '0);
      write_code(CSR_SCAN_FRAME4, '1);
      write_code(CSR_MONITOR, '0);
      queue_random_phase(PHASE_ITEMS);
      settle_block();

      write_code(CSR_ADV_FRAME4, '1);
      write_code(CSR_SCAN_FRAME4, '0);
      write_code(CSR_MONITOR, '1);
      queue_random_phase(PHASE_ITEMS);
      settle_block();

      // A write to the unused index must leave all codes alone.
      write_code(CSR_SPARE, CSR_DATA_W'($urandom));
      write_code(CSR_ADV_FRAME4, CSR_DATA_W'($urandom));
      write_code(CSR_SCAN_FRAME4, CSR_DATA_W'($urandom));
      write_code(CSR_MONITOR, CSR_DATA_W'($urandom));
      queue_random_phase(PHASE_ITEMS);
      settle_block();

      // Monitor code equal to the scan frame code.
      write_code(CSR_ADV_FRAME4, ADV_FRAME4_RESET);
      write_code(CSR_SCAN_FRAME4, SCAN_FRAME4_RESET);
      write_code(CSR_MONITOR, SCAN_FRAME4_RESET);
      queue_random_phase(PHASE_ITEMS);
      settle_block();

      if (failures == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
